@@ design/detection_track_store_merge_top_assert.svh @@
// assertion macros for the detection track store
`ifndef DETECTION_TRACK_STORE_MERGE_TOP_ASSERT_SVH
`define DETECTION_TRACK_STORE_MERGE_TOP_ASSERT_SVH

// antecedent holds, consequent in the same cycle
`define DTSM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds, consequent in the next cycle
`define DTSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/dtsm_pkg.sv @@
// types, constants and match function for the detection track store
package dtsm_pkg;

    localparam int DTSM_MAX_DET  = 32;
    localparam int DTSM_MAX_KEPT = 32;
    localparam logic [7:0] DTSM_MAX_MISS_RST = 8'd3;

    typedef struct packed {
        logic [15:0] score;
        logic [15:0] h;
        logic [15:0] w;
        logic [15:0] y;
        logic [15:0] x;
    } t_det;

    typedef struct packed {
        logic [7:0] miss;
        t_det       det;
    } t_ent;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD,
        ST_CMP,
        ST_KEEP,
        ST_APPEND,
        ST_AP_WR,
        ST_DUMP,
        ST_DU_LD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic st_rd_k;
        logic i_inc;
        logic ent_load;
        logic fr_rd0;
        logic fr_rd_next;
        logic j_clr;
        logic keep_wr;
        logic ap_wr;
        logic commit;
        logic out_load;
        logic out_empty;
        logic k_inc;
    } t_cmd;

    typedef struct packed {
        logic in_fire;
        logic in_last;
        logic i_done;
        logic drop;
        logic f_zero;
        logic match;
        logic j_last;
        logic ap_done;
        logic store_empty;
        logic out_fire;
        logic out_last;
    } t_sts;

    function automatic logic axis_apart(logic [15:0] a, logic [15:0] sa,
                                        logic [15:0] b, logic [15:0] sb);
        logic [17:0] d;
        logic        res;
        if (b > a) begin
            d   = {16'(b - a), 2'b00};
            res = d > {2'b00, sa};
        end else begin
            d   = {16'(a - b), 2'b00};
            res = d > {2'b00, sb};
        end
        return res;
    endfunction

    function automatic logic boxes_match(t_det d, t_det m);
        return !axis_apart(d.x, d.w, m.x, m.w) && !axis_apart(d.y, d.h, m.y, m.h);
    endfunction

endpackage

@@ design/dtsm_ram.sv @@
// generic single write, single read ram with registered read data
module dtsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/dtsm_ctrl.sv @@
// merge and dump sequencer for the detection track store
module dtsm_ctrl import dtsm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_fire && i_sts.in_last) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.i_done) begin
                    o_cmd.j_clr = 1'b1;
                    n_state     = ST_APPEND;
                end else begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.ent_load = 1'b1;
                priority if (i_sts.drop) begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = ST_SCAN;
                end else if (i_sts.f_zero) begin
                    n_state = ST_KEEP;
                end else begin
                    o_cmd.fr_rd0 = 1'b1;
                    n_state      = ST_CMP;
                end
            end
            ST_CMP: begin
                o_cmd.fr_rd_next = 1'b1;
                priority if (i_sts.match) begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = ST_SCAN;
                end else if (i_sts.j_last) begin
                    n_state = ST_KEEP;
                end
            end
            ST_KEEP: begin
                o_cmd.keep_wr = 1'b1;
                o_cmd.i_inc   = 1'b1;
                n_state       = ST_SCAN;
            end
            ST_APPEND: begin
                if (i_sts.ap_done) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_DUMP;
                end else begin
                    n_state = ST_AP_WR;
                end
            end
            ST_AP_WR: begin
                o_cmd.ap_wr = 1'b1;
                n_state     = ST_APPEND;
            end
            ST_DUMP: begin
                o_cmd.st_rd_k = 1'b1;
                if (i_sts.store_empty) begin
                    o_cmd.out_empty = 1'b1;
                    n_state         = ST_OUT;
                end else begin
                    n_state = ST_DU_LD;
                end
            end
            ST_DU_LD: begin
                o_cmd.out_load = 1'b1;
                n_state        = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_fire) begin
                    if (i_sts.out_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = ST_DUMP;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/dtsm_dp.sv @@
// frame buffer, track table, counters and output register
module dtsm_dp import dtsm_pkg::*; #(
    parameter int MAX_DETECTIONS = DTSM_MAX_DET,
    parameter int MAX_KEPT       = DTSM_MAX_KEPT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_s_tvalid,
    input  logic [79:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_s_tlast,
    input  logic        i_m_tready,
    output logic        o_m_tvalid,
    output logic [87:0] o_m_tdata,
    output logic        o_m_tuser,
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    input  logic [7:0]  i_cfg_data
);

    localparam int S   = MAX_KEPT + MAX_DETECTIONS;
    localparam int SW  = $clog2(S + 1);
    localparam int SAW = $clog2(S);
    localparam int FCW = $clog2(MAX_DETECTIONS + 1);
    localparam int FAW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;

    logic [FCW-1:0] r_fcount, r_j;
    logic [SW-1:0]  r_scount, r_i, r_kept, r_k;
    logic [7:0]     r_max_miss;
    t_ent           r_ent, r_out;
    logic           r_out_valid, r_out_user, r_out_last;

    logic           in_fire, fr_we, st_we, kept_full;
    logic [FCW-1:0] n_jp1;
    logic [FAW-1:0] fr_raddr;
    t_det           fr_rdata;
    t_ent           st_rdata, st_wdata;

    assign in_fire   = i_s_tvalid && i_cmd.in_ready;
    assign fr_we     = in_fire && i_s_tuser && (r_fcount < FCW'(MAX_DETECTIONS));
    assign kept_full = r_kept >= SW'(MAX_KEPT);
    assign st_we     = (i_cmd.keep_wr && !kept_full) || i_cmd.ap_wr;
    assign n_jp1     = r_j + FCW'(1);

    always_comb begin
        priority if (i_cmd.fr_rd_next) begin
            fr_raddr = n_jp1[FAW-1:0];
        end else if (i_cmd.fr_rd0) begin
            fr_raddr = '0;
        end else begin
            fr_raddr = r_j[FAW-1:0];
        end
        if (i_cmd.ap_wr) begin
            st_wdata = '{miss: 8'd0, det: fr_rdata};
        end else begin
            st_wdata = '{miss: 8'(r_ent.miss + 8'd1), det: r_ent.det};
        end
    end

    dtsm_ram #(.WIDTH(80), .DEPTH(MAX_DETECTIONS)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (r_fcount[FAW-1:0]),
        .i_wdata (i_s_tdata),
        .i_raddr (fr_raddr),
        .o_rdata (fr_rdata)
    );

    dtsm_ram #(.WIDTH(88), .DEPTH(S)) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_kept[SAW-1:0]),
        .i_wdata (st_wdata),
        .i_raddr (i_cmd.st_rd_k ? r_k[SAW-1:0] : r_i[SAW-1:0]),
        .o_rdata (st_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcount    <= '0;
            r_scount    <= '0;
            r_i         <= '0;
            r_kept      <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_max_miss  <= DTSM_MAX_MISS_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_miss <= i_cfg_data;
            end
            if (fr_we) begin
                r_fcount <= r_fcount + FCW'(1);
            end
            if (in_fire && i_s_tlast) begin
                r_i    <= '0;
                r_kept <= '0;
            end
            if (i_cmd.i_inc) begin
                r_i <= r_i + SW'(1);
            end
            if (st_we) begin
                r_kept <= r_kept + SW'(1);
            end
            if (i_cmd.fr_rd0 || i_cmd.j_clr) begin
                r_j <= '0;
            end else if (i_cmd.fr_rd_next || i_cmd.ap_wr) begin
                r_j <= n_jp1;
            end
            if (i_cmd.commit) begin
                r_scount <= r_kept;
                r_fcount <= '0;
                r_k      <= '0;
            end
            if (i_cmd.k_inc) begin
                r_k <= r_k + SW'(1);
            end
            if (i_cmd.out_load || i_cmd.out_empty) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_load) begin
            r_ent <= st_rdata;
        end
        if (i_cmd.out_load) begin
            r_out      <= st_rdata;
            r_out_user <= 1'b1;
            r_out_last <= r_k == SW'(r_scount - SW'(1));
        end else if (i_cmd.out_empty) begin
            r_out      <= '0;
            r_out_user <= 1'b0;
            r_out_last <= 1'b1;
        end
    end

    always_comb begin
        o_sts.in_fire     = in_fire;
        o_sts.in_last     = i_s_tlast;
        o_sts.i_done      = r_i == r_scount;
        o_sts.drop        = st_rdata.miss >= r_max_miss;
        o_sts.f_zero      = r_fcount == '0;
        o_sts.match       = boxes_match(fr_rdata, r_ent.det);
        o_sts.j_last      = r_j == FCW'(r_fcount - FCW'(1));
        o_sts.ap_done     = r_j == r_fcount;
        o_sts.store_empty = r_scount == '0;
        o_sts.out_fire    = r_out_valid && i_m_tready;
        o_sts.out_last    = r_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

endmodule

@@ design/detection_track_store_merge_top.sv @@
// detection track store merge, top level
// ready is high for items without frame end and drops after a frame-end item
// frame-end merge: each stored entry is dropped at the miss limit, else compared with
// the buffered boxes via one frame ram read port and kept if unmatched and room remains;
// then each buffered box is appended, then each entry is emitted
// synchronous active-low reset empties the store and the frame buffer, max_miss to 3
module detection_track_store_merge_top import dtsm_pkg::*; #(
    parameter int MAX_DETECTIONS = DTSM_MAX_DET,
    parameter int MAX_KEPT       = DTSM_MAX_KEPT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,   // box_x, box_y, box_w, box_h, score
    input  logic        i_s_tuser,   // is_detection
    input  logic        i_s_tlast,   // last_in_frame
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata,   // out_x, out_y, out_w, out_h, out_score, miss_count
    output logic        o_m_tuser,   // entry_valid
    output logic        o_m_tlast,   // last_entry
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data   // max_miss
);

    t_cmd cmd;
    t_sts sts;

    dtsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    dtsm_dp #(
        .MAX_DETECTIONS (MAX_DETECTIONS),
        .MAX_KEPT       (MAX_KEPT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data)
    );

    assign o_s_tready  = cmd.in_ready;
    assign o_cfg_ready = 1'b1;

endmodule

@@ design/dtsm_chk.sv @@
// port-level checks for the detection track store
`include "detection_track_store_merge_top_assert.svh"
module dtsm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [87:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        o_m_tlast
);

    `DTSM_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid, "output dropped")
    `DTSM_ASSERT_NOW(a_no_overlap, o_m_tvalid, !o_s_tready, "input taken during dump")
    `DTSM_ASSERT_NOW(a_empty_store, o_m_tvalid && !o_m_tuser, o_m_tlast && (o_m_tdata == 88'd0), "bad empty result")
    `DTSM_ASSERT_NEXT(a_merge_busy, i_s_tvalid && o_s_tready && i_s_tlast, !o_s_tready, "ready after frame end")

endmodule

bind detection_track_store_merge_top dtsm_chk u_chk (.*);

@@ test/tb_top.sv @@
// self-checking testbench for the detection track store merge block
module tb_top;
    import dtsm_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 3000;

    typedef struct packed {
        logic        last;
        logic        is_det;
        t_det        det;
    } t_item;

    typedef struct packed {
        logic        last;
        logic        valid;
        logic [7:0]  miss;
        t_det        det;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    detection_track_store_merge_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    t_item   pending_items[$];
    t_result expected_entries[$];
    int      errors;
    int      idle_cycles;
    bit      no_idle;
    bit      in_acc;

    // tracking model state
    t_det       frm_boxes[DTSM_MAX_DET];
    int         frm_cnt;
    t_det       trk_boxes[DTSM_MAX_DET + DTSM_MAX_KEPT];
    logic [7:0] trk_miss[DTSM_MAX_DET + DTSM_MAX_KEPT];
    int         trk_cnt;
    logic [7:0] miss_limit;

    always #2 i_clk = ~i_clk;

    function automatic bit apart(logic [15:0] a, logic [15:0] sa, logic [15:0] b,
                                 logic [15:0] sb);
        logic [17:0] diff;
        if (b > a) begin
            diff = {b - a, 2'b00};
            return diff > {2'b00, sa};
        end
        diff = {a - b, 2'b00};
        return diff > {2'b00, sb};
    endfunction

    task automatic predict_tracks(input t_item it);
        int      kept;
        bit      hit;
        t_result r;
        if (it.is_det && frm_cnt < DTSM_MAX_DET) begin
            frm_boxes[frm_cnt] = it.det;
            frm_cnt++;
        end
        if (!it.last) return;
        kept = 0;
        for (int i = 0; i < trk_cnt; i++) begin
            hit = 0;
            if (trk_miss[i] >= miss_limit) continue;
            for (int j = 0; j < frm_cnt; j++)
                if (!apart(frm_boxes[j].x, frm_boxes[j].w, trk_boxes[i].x, trk_boxes[i].w) &&
                    !apart(frm_boxes[j].y, frm_boxes[j].h, trk_boxes[i].y, trk_boxes[i].h))
                    hit = 1;
            if (hit || kept >= DTSM_MAX_KEPT) continue;
            trk_boxes[kept] = trk_boxes[i];
            trk_miss[kept]  = trk_miss[i] + 8'd1;
            kept++;
        end
        for (int j = 0; j < frm_cnt; j++) begin
            trk_boxes[kept] = frm_boxes[j];
            trk_miss[kept]  = 8'd0;
            kept++;
        end
        trk_cnt = kept;
        frm_cnt = 0;
        if (trk_cnt == 0) begin
            r = '0;
            r.last = 1;
            expected_entries.push_back(r);
        end
        for (int k = 0; k < trk_cnt; k++) begin
            r.det   = trk_boxes[k];
            r.miss  = trk_miss[k];
            r.valid = 1;
            r.last  = (k == trk_cnt - 1);
            expected_entries.push_back(r);
        end
    endtask

    function automatic t_item rand_box(bit last, int spread);
        t_item it;
        it.is_det    = 1;
        it.last      = last;
        it.det.x     = 16'(32768 + $urandom_range(0, spread) - spread / 2);
        it.det.y     = 16'(32768 + $urandom_range(0, spread) - spread / 2);
        it.det.w     = 16'($urandom_range(0, 65535));
        it.det.h     = 16'($urandom_range(0, 65535));
        it.det.score = 16'($urandom);
        if ($urandom_range(0, 9) == 0) it.det = t_det'({$urandom, $urandom, $urandom});
        return it;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_tvalid || in_acc) begin
                if (pending_items.size() != 0 && (no_idle || $urandom_range(0, 99) >= 26)) begin
                    s_tvalid <= 1;
                    s_tdata  <= pending_items[0].det;
                    s_tuser  <= pending_items[0].is_det;
                    s_tlast  <= pending_items[0].last;
                end else begin
                    s_tvalid <= 0;
                end
            end
            m_tready <= no_idle || $urandom_range(0, 99) >= 26;
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n) begin
            in_acc = s_tvalid && s_tready;
            if (in_acc) begin
                predict_tracks(pending_items.pop_front());
            end
            if (in_acc || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (m_tvalid && m_tready) begin
                got = {m_tlast, m_tuser, m_tdata};
                if (expected_entries.size() == 0) begin
                    $display("%0t unexpected transaction, actual %h", $time, got);
                    errors++;
                end else begin
                    want = expected_entries.pop_front();
                    if (got.det.x != want.det.x || got.det.y != want.det.y ||
                        got.det.w != want.det.w || got.det.h != want.det.h ||
                        got.det.score != want.det.score || got.miss != want.miss ||
                        got.valid != want.valid || got.last != want.last) begin
                        $display("%0t mismatch, expected %h actual %h", $time, want, got);
                        errors++;
                    end
                end
            end
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_entries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        @(negedge i_clk);
        cfg_valid <= 1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        miss_limit = value;
        @(negedge i_clk);
        cfg_valid <= 0;
    endtask

    task automatic push_frame(input int nbox, input int spread);
        t_item it;
        if (nbox == 0) begin
            it = t_item'($urandom);
            it.is_det = 0;
            it.last   = 1;
            pending_items.push_back(it);
            return;
        end
        for (int i = 0; i < nbox; i++) begin
            it = rand_box(i == nbox - 1, spread);
            if ($urandom_range(0, 15) == 0) it.is_det = 0;
            pending_items.push_back(it);
        end
    endtask

    initial begin
        t_item it;
        i_clk = 0; i_rst_n = 0; s_tvalid = 0; s_tdata = '0; s_tuser = 0; s_tlast = 0;
        m_tready = 0; cfg_valid = 0; cfg_data = '0;
        errors = 0; idle_cycles = 0; no_idle = 0; in_acc = 0;
        frm_cnt = 0; trk_cnt = 0; miss_limit = DTSM_MAX_MISS_RST;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1;

        // directed: empty frame, field extremes, non-box item with ones, overflow
        push_frame(0, 0);
        it = '0; it.is_det = 1; pending_items.push_back(it);
        it.det = '1; it.last = 1; pending_items.push_back(it);
        it = '1; it.is_det = 0; it.last = 0; pending_items.push_back(it);
        it.last = 1; pending_items.push_back(it);
        it.det = '{x: 16'd1000, y: 16'd1000, w: 16'd400, h: 16'd400, score: 16'd7};
        it.is_det = 1; it.last = 1; pending_items.push_back(it);
        it.det.x = 16'd1100; it.det.w = 16'd0; pending_items.push_back(it);
        it.det.x = 16'd1101; pending_items.push_back(it);
        wait_idle();
        write_limit(8'd0);
        push_frame(3, 65535);
        push_frame(0, 0);
        wait_idle();
        write_limit(8'd255);
        for (int f = 0; f < 4; f++) push_frame(34 - f, 65535);
        wait_idle();

        // random frames, varying limits
        for (int phase = 0; phase < 5; phase++) begin
            write_limit(phase == 4 ? 8'd1 : 8'($urandom_range(0, 6)));
            no_idle = (phase == 2);
            for (int f = 0; f < 8; f++)
                push_frame($urandom_range(0, 8), $urandom_range(0, 3) == 0 ? 65535 : 4000);
            wait_idle();
        end
        no_idle = 0;
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
